/* rtl/dsrb_pkg.sv */
// dsrb_pkg: sizes, the framing character and the request/response word types
// for the delimited sentence ring buffer. No dependencies.
package dsrb_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_BYTES = 128;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   // a slot counts at most SLOT_BYTES-1 bytes, so lengths and offsets share a width
   localparam int LEN_W  = $clog2(SLOT_BYTES);
   localparam int ADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES);
   localparam int STORE_DEPTH = SLOT_COUNT * SLOT_BYTES;

   localparam logic [7:0] START_CHAR = 8'h24;

   localparam logic MODE_RECEIVE = 1'b0;
   localparam logic MODE_READ    = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic       available;
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       last;
   } rsp_word_type;

endpackage

/* rtl/delimited_sentence_ring_buffer.sv */
// delimited_sentence_ring_buffer: frames received bytes into sentences in a ring of slots.
// Depends on dsrb_pkg (sizes, word types) and dsrb_ram (sentence store).
//
// Usage:
//   A request word is taken on a rising edge with start high and busy low; busy
//   is always low, so a word may be issued every cycle. mode 0 stores rx_byte
//   in the slot being filled ('$' opens the next slot, or restarts the current
//   one when the ring is full) and gives no response. mode 1 pops the next byte
//   of the oldest completed sentence and gives exactly one response word.
//   The response appears on rsp_word with rsp_valid high for one cycle, the
//   cycle after the read request was taken (throughput one word per
//   cycle). The latency is set by the registered read port of the sentence
//   store. The receiver cannot stall: rsp_valid is a strobe and must be taken.
//   Reset (synchronous, active high) empties the ring: head, tail, fill length
//   and read offset go to zero. The store itself is not cleared; only bytes
//   that were written are ever read back. No clearing pass is needed, so
//   requests are taken in the first cycle after reset.
module delimited_sentence_ring_buffer
   import dsrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(SLOT_BYTES - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0]  tail_len_ff, tail_len_in;
   logic [LEN_W-1:0]  offset_ff, offset_in;
   // lengths of completed slots, written when the tail leaves a slot
   logic [LEN_W-1:0]  slot_len_ff [SLOT_COUNT];

   logic rsp_valid_ff, rsp_valid_in;
   logic avail_ff, avail_in;
   logic bvalid_ff, bvalid_in;
   logic last_ff, last_in;

   logic              accept;
   logic              do_recv, do_read;
   logic              is_start;
   logic [SLOT_W-1:0] tail_next, head_next;
   logic              advance;
   logic [LEN_W-1:0]  wr_pos;
   logic [LEN_W-1:0]  head_len;
   logic [LEN_W-1:0]  rd_off;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        rd_data;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign do_recv = accept && (req_word.mode == MODE_RECEIVE);
   assign do_read = accept && (req_word.mode == MODE_READ);

   assign tail_next = (tail_ff == SLOT_LAST) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == SLOT_LAST) ? '0 : head_ff + 1'b1;
   assign is_start  = (req_word.rx_byte == START_CHAR);
   assign advance   = do_recv && is_start && (tail_next != head_ff);

   assign head_len = slot_len_ff[head_ff];
   assign rd_off   = (offset_ff > LEN_MAX) ? LEN_MAX : offset_ff;

   always_comb begin
      tail_in      = tail_ff;
      tail_len_in  = tail_len_ff;
      head_in      = head_ff;
      offset_in    = offset_ff;
      wr_pos       = tail_len_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = 1'b0;
      avail_in     = 1'b0;
      bvalid_in    = 1'b0;
      last_in      = 1'b0;

      if (do_recv) begin
         // '$' opens a fresh slot, or restarts this one when the ring is full
         if (is_start) begin
            wr_pos = '0;
            if (advance) begin
               tail_in = tail_next;
            end
         end
         wr_en       = 1'b1;
         tail_len_in = (wr_pos < LEN_MAX) ? wr_pos + 1'b1 : wr_pos;
      end

      if (do_read) begin
         rsp_valid_in = 1'b1;
         if (head_ff != tail_ff) begin
            avail_in = 1'b1;
            if (head_len == '0) begin
               last_in   = 1'b1;
               head_in   = head_next;
               offset_in = '0;
            end else begin
               bvalid_in = 1'b1;
               rd_en     = 1'b1;
               if (({1'b0, rd_off} + 1'b1) >= {1'b0, head_len}) begin
                  last_in   = 1'b1;
                  head_in   = head_next;
                  offset_in = '0;
               end else begin
                  offset_in = rd_off + 1'b1;
               end
            end
         end
      end
   end

   assign wr_addr = ADDR_W'(tail_in) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wr_pos);
   assign rd_addr = ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_off);

   dsrb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         tail_len_ff  <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         tail_len_ff  <= tail_len_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_len_ff[tail_ff] <= tail_len_ff;
      end
      avail_ff  <= avail_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_word.available  = avail_ff;
   assign rsp_word.byte_valid = bvalid_ff;
   assign rsp_word.out_byte   = bvalid_ff ? rd_data : 8'h00;
   assign rsp_word.last       = last_ff;

   // every read word gives one response next cycle, a receive word none
   a_read_rsp : assert property (@(posedge clock) disable iff (reset)
      do_read |=> rsp_valid)
      else $error("read word without response");

   a_recv_quiet : assert property (@(posedge clock) disable iff (reset)
      do_recv |=> !rsp_valid)
      else $error("response after receive word");

   a_empty_rsp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.available) |-> (!rsp_word.byte_valid && !rsp_word.last))
      else $error("byte given with no sentence available");

   a_offset_range : assert property (@(posedge clock) disable iff (reset)
      (head_ff != tail_ff && offset_ff != '0) |-> (offset_ff < head_len))
      else $error("read offset past slot length");

endmodule

/* rtl/dsrb_ram.sv */
// dsrb_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// Width and depth come from parameters; no package dependency.
module dsrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for delimited_sentence_ring_buffer, with its own framing predictor.
// Depends on dsrb_pkg for the word types, sizes and the '$' framing character.
module tb;
   import dsrb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 40;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   // predictor copy of the ring
   logic [7:0]        ring_store [SLOT_COUNT][SLOT_BYTES];
   logic [LEN_W-1:0]  ring_len [SLOT_COUNT];
   logic [SLOT_W-1:0] ring_head;
   logic [SLOT_W-1:0] ring_tail;
   logic [LEN_W-1:0]  ring_offset;

   rsp_word_type bytes_due[$];
   int           mismatches = 0;
   int           cycle_count = 0;
   bit           gaps_on;

   delimited_sentence_ring_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [SLOT_W-1:0] following_slot(logic [SLOT_W-1:0] s);
      return (int'(s) == SLOT_COUNT - 1) ? '0 : s + 1'b1;
   endfunction

   function void frame_rx_byte(logic [7:0] b);
      logic [SLOT_W-1:0] n;
      int                len;
      if (b == START_CHAR) begin
         n = following_slot(ring_tail);
         // ring full: the partial sentence is dropped and the slot restarts
         if (n == ring_head) ring_len[ring_tail] = '0;
         else ring_tail = n;
      end
      len = int'(ring_len[ring_tail]);
      ring_store[ring_tail][len] = b;
      // saturated slots keep overwriting the last position
      if (len < SLOT_BYTES - 1) len++;
      ring_len[ring_tail] = LEN_W'(len);
   endfunction

   function void free_head_slot();
      ring_len[ring_head] = '0;
      ring_head = following_slot(ring_head);
      ring_offset = '0;
   endfunction

   function rsp_word_type pop_sentence_byte();
      rsp_word_type r;
      r = '0;
      if (ring_head == ring_tail) return r;
      r.available = 1'b1;
      if (ring_len[ring_head] == 0) begin
         r.last = 1'b1;
         free_head_slot();
         return r;
      end
      r.byte_valid = 1'b1;
      r.out_byte = ring_store[ring_head][ring_offset];
      if (int'(ring_offset) + 1 >= int'(ring_len[ring_head])) begin
         r.last = 1'b1;
         free_head_slot();
      end else begin
         ring_offset = ring_offset + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [7:0] random_payload_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == START_CHAR) b = ~b;
      return b;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (mismatches < MAX_REPORTS)
         $display("tb: mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // called just after a falling edge; returns just after a falling edge, once the word has been taken on a rising edge
   task automatic send_item(input req_word_type w);
      while (gaps_on && $urandom_range(0, 99) < 18) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_word = w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
      if (w.mode == MODE_READ) bytes_due.push_back(pop_sentence_byte());
      else frame_rx_byte(w.rx_byte);
      start = 1'b0;
   endtask

   task automatic send_read();
      send_item('{mode: MODE_READ, rx_byte: 8'($urandom_range(0, 255))});
   endtask

   task automatic send_rx(input logic [7:0] b);
      send_item('{mode: MODE_RECEIVE, rx_byte: b});
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (bytes_due.size() == 0) begin
            report_mismatch("unexpected response word", 0, 32'(rsp_word));
         end else begin
            want = bytes_due.pop_front();
            if (rsp_word.available !== want.available)
               report_mismatch("available", want.available, rsp_word.available);
            if (rsp_word.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", want.byte_valid, rsp_word.byte_valid);
            if (rsp_word.out_byte !== want.out_byte)
               report_mismatch("out_byte", want.out_byte, rsp_word.out_byte);
            if (rsp_word.last !== want.last)
               report_mismatch("last", want.last, rsp_word.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_read_empty_ring();
      send_read();
   endtask

   // a '$' straight after reset leaves slot 0 completed with no bytes
   task automatic test_empty_sentence();
      send_rx(START_CHAR);
      send_read();
      send_read();
   endtask

   task automatic test_field_extremes();
      send_rx(8'h00);
      send_rx(8'hFF);
      send_rx(8'h7F);
      send_rx(8'h80);
      send_rx(START_CHAR);
      repeat (5) send_read();
   endtask

   task automatic test_framed_sentences(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         // mostly short sentences, now and then one near or past the slot size
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 12);
         send_rx(START_CHAR);
         sent++;
         repeat (len) begin
            send_rx(random_payload_byte());
            sent++;
            if ($urandom_range(0, 99) < 35) begin
               send_read();
               sent++;
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(0, 30)) begin
               send_read();
               sent++;
            end
         end
      end
   endtask

   task automatic test_ring_overflow();
      repeat (3) begin
         repeat (SLOT_COUNT + 2) begin
            send_rx(START_CHAR);
            repeat ($urandom_range(0, 3)) send_rx(random_payload_byte());
         end
         while (ring_head != ring_tail) send_read();
         send_read();
      end
   endtask

   task automatic test_random_noise(input int n_items);
      logic [7:0] b;
      repeat (n_items) begin
         b = ($urandom_range(0, 99) < 15) ? START_CHAR : 8'($urandom_range(0, 255));
         send_item('{mode: 1'($urandom_range(0, 1)), rx_byte: b});
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      gaps_on = 1'b1;
      ring_head = '0;
      ring_tail = '0;
      ring_offset = '0;
      for (int s = 0; s < SLOT_COUNT; s++) ring_len[s] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_read_empty_ring();
      test_empty_sentence();
      test_field_extremes();
      test_framed_sentences(500);
      gaps_on = 1'b0;
      test_framed_sentences(300);
      gaps_on = 1'b1;
      test_ring_overflow();
      test_random_noise(320);

      start = 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
